// ===== rtl/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants of the best-fit heap allocator
// Operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package bfha_pkg;
  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_OFFSET_BITS  = 20;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int ARENA_BITS       = 21;
  localparam int FIELD_BITS       = 20;
  localparam logic [ARENA_BITS-1:0] ARENA_RESET = 21'd65536;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_NOBLK = 2'd2,
    ST_RSVD  = 2'd3
  } result_code_t;
endpackage

// ===== rtl/best_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit: best-fit allocator with coalescing
// Address-ordered block table in RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// channel   direction  signals
// command   in         start, operation, request_size, payload_offset; busy out
// result    out        done, status, result_offset, moved, copy_bytes
// config    in         cfg_we, cfg_data (arena_size)
//
// Requests walk the table one entry at a time; allocate walks once for best
// fit and once to shift entries on split, free walks to find and to shift,
// resize up to five walks (find, best fit, shift on split, find again, shift
// on merge).
// Reset clears the table to one free block (used bits are flip-flops; the
// count bounds every read). Results cannot be stalled.
module best_fit_heap_allocator_unit #(
  parameter int MAX_BLOCKS   = bfha_pkg::DEF_MAX_BLOCKS,
  parameter int OFFSET_BITS  = bfha_pkg::DEF_OFFSET_BITS,
  parameter int HEADER_BYTES = bfha_pkg::DEF_HEADER_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation,
  input  logic [bfha_pkg::FIELD_BITS-1:0] request_size,
  input  logic [bfha_pkg::FIELD_BITS-1:0] payload_offset,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [bfha_pkg::FIELD_BITS-1:0] result_offset,
  output logic                            moved,
  output logic [bfha_pkg::FIELD_BITS-1:0] copy_bytes,
  input  logic                            cfg_we,
  input  logic [bfha_pkg::ARENA_BITS-1:0] cfg_data
);
  import bfha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = (OFFSET_BITS > ARENA_BITS ? OFFSET_BITS : ARENA_BITS) + 2;
  localparam logic [AW-1:0] H = AW'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

  // where a finished table shift returns to
  localparam logic [1:0] RET_ALLOC  = 2'd0;
  localparam logic [1:0] RET_SHRINK = 2'd1;
  localparam logic [1:0] RET_MOVE   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_FRD, S_FCHK, S_DISP, S_ARD, S_ARD2, S_ACHK, S_ADEC,
    S_SHRD, S_SHWR, S_PUT, S_FREE, S_RMRD, S_RMWR, S_RSZ, S_RSZ2,
    S_RSZ3, S_MVFREE, S_OUT
  } state_t;

  state_t st;
  logic [ARENA_BITS-1:0] arena;
  logic [MAX_BLOCKS-1:0] used;
  logic [CW-1:0] cnt;
  logic [1:0] op;
  logic [FIELD_BITS-1:0] rsz, pay;
  logic [IW-1:0] idx, best, tgt, hi;
  logic [AW-1:0] cur, nxt, bst, bsz, sz, tgt_start;
  logic best_used, found, mv_phase;
  logic [CW-1:0] ins_at;
  logic [AW-1:0] ins_val;
  logic [1:0] ret;
  logic [FIELD_BITS-1:0] old_bs;

  // table RAM
  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [OFFSET_BITS-1:0] wdata, rdata;
  bfha_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_BLOCKS)) u_tbl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  // entry zero is fixed at 0; the RAM mirrors other entries
  logic [AW-1:0] rd;
  logic [IW-1:0] raddr_q;
  assign rd = (raddr_q == '0) ? '0 : AW'(rdata);

  function automatic logic [AW-1:0] psize(logic [AW-1:0] s, logic [AW-1:0] e);
    return (e > s + H) ? e - s - H : '0;
  endfunction

  assign busy = (st != S_IDLE);

  // size compare for best fit
  logic [AW-1:0] csz;
  logic last_i, better;
  always_comb begin
    csz = psize(cur, nxt);
    last_i = (CW'(idx) + 1'b1 == cnt);
    better = 1'b0;
    if (!used[idx]) begin
      if (best_used) better = 1'b1;
      else if (last_i && csz == sz) better = 1'b1;
      else if (last_i && csz < H + sz) better = 1'b0;
      else if (last_i && csz == H + sz) better = 1'b1;
      else if (csz < sz) better = 1'b0;
      else if (csz == sz) better = 1'b1;
      else if (bsz > sz + H && csz <= sz + H) better = 1'b0;
      else better = (csz - sz) < (bsz - sz);
    end
  end

  // single sequencer
  always_ff @(posedge clk) begin
    we <= 1'b0;
    done <= 1'b0;
    raddr_q <= raddr;
    if (cfg_we) arena <= cfg_data;
    if (rst) begin
      st <= S_IDLE; arena <= ARENA_RESET; used <= '0; cnt <= CW'(1);
      raddr <= '0; raddr_q <= '0;
    end else begin
      case (st)
        S_IDLE: if (start) begin
          op <= operation; rsz <= request_size; pay <= payload_offset;
          status <= ST_OK; result_offset <= '0; moved <= 1'b0; copy_bytes <= '0;
          mv_phase <= 1'b0;
          idx <= '0; raddr <= '0; found <= 1'b0;
          if (operation == OP_ALLOC) begin
            sz <= AW'(request_size); st <= S_ARD; ret <= RET_ALLOC;
          end else if (operation == OP_NONE) st <= S_OUT;
          else st <= S_FRD;
        end
        // find block by payload offset
        S_FRD: st <= S_FCHK;
        S_FCHK: begin
          if (rd + H == AW'(pay) && !found) begin
            found <= 1'b1; tgt <= idx; tgt_start <= rd;
          end
          if (CW'(idx) + 1'b1 >= cnt) st <= S_DISP;
          else begin idx <= idx + 1'b1; raddr <= idx + 1'b1; st <= S_FRD; end
        end
        S_DISP: begin
          if (!found || !used[tgt]) begin
            status <= (mv_phase) ? status : ST_NOBLK; st <= S_OUT;
          end else if (op == OP_FREE || rsz == '0 || mv_phase) begin
            st <= S_FREE;
          end else begin
            raddr <= tgt + 1'b1; st <= S_RSZ;
          end
        end
        // best-fit scan, one entry per pass through S_ACHK and S_ADEC
        S_ARD: begin raddr <= idx + 1'b1; st <= S_ARD2; end
        S_ARD2: begin cur <= rd; st <= S_ACHK; end
        S_ACHK: begin
          nxt <= (last_i) ? AW'(arena) : rd;
          raddr <= idx + 2'd2;
          st <= S_ADEC;
        end
        S_ADEC: begin
          if (idx == '0 || better) begin
            best <= idx; bst <= cur; bsz <= csz; best_used <= used[idx];
          end
          if (last_i || (idx != '0 && better && csz == sz)) st <= S_PUT;
          else begin idx <= idx + 1'b1; cur <= nxt; st <= S_ACHK; end
        end
        S_PUT: begin
          if (best_used || bsz < sz) begin
            status <= ST_OOM; result_offset <= '0; st <= S_OUT;
            if (ret == RET_MOVE) begin moved <= 1'b0; copy_bytes <= '0; end
          end else begin
            used[best] <= 1'b1;
            result_offset <= FIELD_BITS'(bst + H);
            if (ret == RET_MOVE) begin moved <= 1'b1; copy_bytes <= old_bs; end
            if (bsz - sz > H && cnt < MAXC) begin
              ins_at <= CW'(best) + 1'b1; ins_val <= bst + H + sz;
              hi <= IW'(cnt); raddr <= IW'(cnt - 1'b1); st <= S_SHRD;
            end else if (ret == RET_MOVE) begin
              mv_phase <= 1'b1; found <= 1'b0; idx <= '0; raddr <= '0; st <= S_FRD;
            end else st <= S_OUT;
          end
        end
        // insert: shift entries up one at a time through S_SHRD and S_SHWR
        S_SHRD: st <= S_SHWR;
        S_SHWR: begin
          if (CW'(hi) > ins_at) begin
            we <= 1'b1; waddr <= hi; wdata <= OFFSET_BITS'(rd);
            used[hi] <= used[hi-1'b1];
            hi <= hi - 1'b1; raddr <= hi - 2'd2; st <= S_SHRD;
          end else begin
            we <= 1'b1; waddr <= hi; wdata <= OFFSET_BITS'(ins_val);
            used[hi] <= 1'b0; cnt <= cnt + 1'b1;
            if (ret == RET_MOVE) begin
              mv_phase <= 1'b1; found <= 1'b0; idx <= '0; raddr <= '0; st <= S_FRD;
            end else st <= S_OUT;
          end
        end
        // free and merge
        S_FREE: begin
          used[tgt] <= 1'b0;
          if (tgt != '0 && !used[tgt-1'b1]) begin
            if (CW'(tgt) + 1'b1 < cnt && !used[tgt+1'b1]) begin
              st <= S_RMRD; raddr <= tgt + 2'd2;
              hi <= tgt; cnt <= cnt - 1'b1; // drop two: first pass removes tgt+1
              ins_at <= CW'(2);
            end else begin
              hi <= tgt; raddr <= tgt + 1'b1; ins_at <= CW'(1); st <= S_RMRD;
            end
          end else if (CW'(tgt) + 1'b1 < cnt && !used[tgt+1'b1]) begin
            hi <= tgt + 1'b1; raddr <= tgt + 2'd2; ins_at <= CW'(1); st <= S_RMRD;
          end else st <= S_OUT;
        end
        // remove ins_at entries starting at hi, one copy per pass through S_RMRD and S_RMWR
        S_RMRD: st <= S_RMWR;
        S_RMWR: begin
          if (CW'(hi) + CW'(ins_at) < cnt + ((ins_at == 2'd2) ? 1'b1 : 1'b0)) begin
            we <= 1'b1; waddr <= hi; wdata <= OFFSET_BITS'(rd);
            used[hi] <= used[IW'(CW'(hi) + CW'(ins_at))];
            hi <= hi + 1'b1; raddr <= IW'(CW'(hi) + CW'(ins_at) + 1'b1); st <= S_RMRD;
          end else begin
            cnt <= cnt - ((ins_at == 2'd2) ? CW'(1) : CW'(ins_at));
            st <= S_OUT;
          end
        end
        // resize: read successor start, then the one after it
        S_RSZ: begin raddr <= tgt + 2'd2; st <= S_RSZ2; end
        S_RSZ2: begin
          nxt <= (CW'(tgt) + 1'b1 < cnt) ? rd : AW'(arena);
          st <= S_RSZ3;
        end
        S_RSZ3: begin
          logic nf;
          logic [AW-1:0] bsv, tot, cut, n2;
          nf = (CW'(tgt) + 1'b1 < cnt) && !used[tgt+1'b1];
          bsv = psize(tgt_start, nxt);
          cut = tgt_start + H + AW'(rsz);
          n2 = (CW'(tgt) + 2'd2 < cnt) ? rd : AW'(arena);
          tot = psize(nxt, n2) + H + bsv;
          result_offset <= pay;
          if (AW'(rsz) <= bsv) begin
            if (bsv - AW'(rsz) > H) begin
              if (nf) begin
                we <= 1'b1; waddr <= tgt + 1'b1; wdata <= OFFSET_BITS'(cut); st <= S_OUT;
              end else if (cnt < MAXC) begin
                ins_at <= CW'(tgt) + 1'b1; ins_val <= cut; ret <= RET_SHRINK;
                hi <= IW'(cnt); raddr <= IW'(cnt - 1'b1); st <= S_SHRD;
              end else st <= S_OUT;
            end else st <= S_OUT;
          end else if (nf && tot >= AW'(rsz)) begin
            if (tot - AW'(rsz) <= H) begin
              hi <= tgt + 1'b1; raddr <= tgt + 2'd2; ins_at <= CW'(1); st <= S_RMRD;
            end else begin
              we <= 1'b1; waddr <= tgt + 1'b1; wdata <= OFFSET_BITS'(cut); st <= S_OUT;
            end
          end else begin
            old_bs <= FIELD_BITS'(bsv); sz <= AW'(rsz); ret <= RET_MOVE;
            idx <= '0; raddr <= '0; st <= S_ARD;
          end
        end
        S_OUT: begin done <= 1'b1; st <= S_IDLE; end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/bfha_ram.sv =====
// ----------------------------------------------------------------------------
// bfha_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read (a read of the written address returns the old data)
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/bfha_checker.sv =====
// ----------------------------------------------------------------------------
// bfha_checker: port-level checks of the allocator
// Result framing against request acceptance.
// ----------------------------------------------------------------------------
module bfha_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [1:0] status,
  input logic moved,
  input logic [bfha_pkg::FIELD_BITS-1:0] copy_bytes
);
  import bfha_pkg::*;

  // a request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");
  // the block is idle while a result is shown
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");
  // a move implies ok status
  a_mv: assert property (@(posedge clk) disable iff (rst)
    done && moved |-> status == ST_OK) else $error("move with error");
  // copy bytes only on a move
  a_cp: assert property (@(posedge clk) disable iff (rst)
    done && !moved |-> copy_bytes == '0) else $error("copy without move");
endmodule

bind best_fit_heap_allocator_unit bfha_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .moved(moved), .copy_bytes(copy_bytes));
